### sv/bracket_balance_checker_top_assert.svh
// ----------------------------------------------------------------------------
// bracket balance checker assertion macros
// shared property forms for the checker's concurrent assertions
// ----------------------------------------------------------------------------
`ifndef BRACKET_BALANCE_CHECKER_TOP_ASSERT_SVH
`define BRACKET_BALANCE_CHECKER_TOP_ASSERT_SVH

// same-cycle implication, off while reset is high
`define BBC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define BBC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg
// types, character codes and error codes of the bracket balance checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bbc_pkg;

   localparam int DEFAULT_STACK_DEPTH = 128;

   localparam int CH_W  = 8;
   localparam int IDX_W = 16;
   localparam int ERR_W = 3;

   localparam logic [IDX_W-1:0] INDEX_MAX = {IDX_W{1'b1}};

   localparam logic [CH_W-1:0] CH_OPEN_SQUARE  = 8'h5B;
   localparam logic [CH_W-1:0] CH_OPEN_CURLY   = 8'h7B;
   localparam logic [CH_W-1:0] CH_OPEN_ROUND   = 8'h28;
   localparam logic [CH_W-1:0] CH_CLOSE_SQUARE = 8'h5D;
   localparam logic [CH_W-1:0] CH_CLOSE_CURLY  = 8'h7D;
   localparam logic [CH_W-1:0] CH_CLOSE_ROUND  = 8'h29;

   typedef logic [1:0] bracket_type;
   localparam bracket_type BR_SQUARE = 2'd0;
   localparam bracket_type BR_CURLY  = 2'd1;
   localparam bracket_type BR_ROUND  = 2'd2;
   localparam bracket_type BR_NONE   = 2'd3;

   typedef logic [ERR_W-1:0] err_type;
   localparam err_type ERR_NONE     = 3'd0;
   localparam err_type ERR_MISMATCH = 3'd1;
   localparam err_type ERR_EMPTY    = 3'd2;
   localparam err_type ERR_UNCLOSED = 3'd3;
   localparam err_type ERR_OVERFLOW = 3'd4;

   typedef struct packed {
      logic [IDX_W-1:0] error_position;
      err_type          error_code;
      logic             correct;
   } rsp_type;

   localparam int RSP_W  = $bits(rsp_type);
   localparam int RSP_TW = ((RSP_W + 7) / 8) * 8;

   function automatic bracket_type opener_type(input logic [CH_W-1:0] c);
      case (c)
         CH_OPEN_SQUARE: opener_type = BR_SQUARE;
         CH_OPEN_CURLY:  opener_type = BR_CURLY;
         CH_OPEN_ROUND:  opener_type = BR_ROUND;
         default:        opener_type = BR_NONE;
      endcase
   endfunction

   function automatic bracket_type closer_type(input logic [CH_W-1:0] c);
      case (c)
         CH_CLOSE_SQUARE: closer_type = BR_SQUARE;
         CH_CLOSE_CURLY:  closer_type = BR_CURLY;
         CH_CLOSE_ROUND:  closer_type = BR_ROUND;
         default:         closer_type = BR_NONE;
      endcase
   endfunction

endpackage

### sv/bracket_balance_checker_top.sv
// ----------------------------------------------------------------------------
// bracket_balance_checker_top
// checks bracket balance of a character stream, one result per expression
//
//   channel   direction   fields
//   req_      in          tdata: ch ; tlast: last
//   rsp_      out         tdata: correct, error_code, error_position
//
// one character per cycle while ready; a result is registered on its last beat.
// top of stack sits in a register, the entry below it is prefetched from
// the stack memory each cycle (registered read, forwarded on a same-entry push).
// synchronous reset empties the stack at once, no clearing pass.
// req_tready drops only while both result registers are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bracket_balance_checker_top #(
   parameter int STACK_DEPTH = bbc_pkg::DEFAULT_STACK_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [bbc_pkg::CH_W-1:0]   req_tdata,   // [7:0] ch
   input  logic                       req_tlast,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [bbc_pkg::RSP_TW-1:0] rsp_tdata    // correct, error_code, error_position
);
   import bbc_pkg::*;

   localparam int DW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);
   localparam logic [DW-1:0] DEPTH_FULL = DW'(STACK_DEPTH);
   localparam logic [DW-1:0] DEPTH_ONE  = DW'(1);
   localparam logic [DW-1:0] DEPTH_TWO  = DW'(2);

   logic [DW-1:0]    depth_ff, depth_in;
   err_type          err_ff, err_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] err_pos_ff, err_pos_in;
   bracket_type      tos_ff, tos_in;
   logic             fwd_ff;
   bracket_type      fwd_data_ff;

   logic             accept;
   bracket_type      op, cl, nos, mem_rd_data;
   logic             wr_en;
   logic [DW-1:0]    depth_dec, rd_depth;
   logic [AW-1:0]    wr_addr, rd_addr;
   logic             res_valid, res_ready;
   rsp_type          res;
   rsp_type          out_data;

   assign accept    = req_tvalid && req_tready;
   assign op        = opener_type(req_tdata);
   assign cl        = closer_type(req_tdata);
   assign nos       = fwd_ff ? fwd_data_ff : mem_rd_data;
   assign depth_dec = depth_ff - DEPTH_ONE;
   assign wr_addr   = depth_dec[AW-1:0];
   assign rd_depth  = depth_in - DEPTH_TWO;
   assign rd_addr   = rd_depth[AW-1:0];

   always_comb begin
      depth_in   = depth_ff;
      err_in     = err_ff;
      idx_in     = idx_ff;
      err_pos_in = err_pos_ff;
      tos_in     = tos_ff;
      wr_en      = 1'b0;
      res        = '0;
      if (accept) begin
         if (err_ff == ERR_NONE) begin
            if (op != BR_NONE) begin
               if (depth_ff == DEPTH_FULL) begin
                  err_in     = ERR_OVERFLOW;
                  err_pos_in = idx_ff;
               end else begin
                  // old top moves into memory below the new top
                  wr_en    = (depth_ff != '0);
                  tos_in   = op;
                  depth_in = depth_ff + DEPTH_ONE;
               end
            end else if (cl != BR_NONE) begin
               if (depth_ff == '0) begin
                  err_in     = ERR_EMPTY;
                  err_pos_in = idx_ff;
               end else if (tos_ff != cl) begin
                  err_in     = ERR_MISMATCH;
                  err_pos_in = idx_ff;
               end else begin
                  tos_in   = nos;
                  depth_in = depth_dec;
               end
            end
         end
         if (idx_ff != INDEX_MAX) begin
            idx_in = idx_ff + IDX_W'(1);
         end
         if (err_in != ERR_NONE) begin
            res.error_code     = err_in;
            res.error_position = err_pos_in;
         end else if (depth_in != '0) begin
            res.error_code     = ERR_UNCLOSED;
            res.error_position = idx_in;
         end else begin
            res.correct        = 1'b1;
            res.error_code     = ERR_NONE;
            res.error_position = idx_in;
         end
         if (req_tlast) begin
            depth_in   = '0;
            err_in     = ERR_NONE;
            idx_in     = '0;
            err_pos_in = '0;
         end
      end
   end

   assign res_valid  = accept && req_tlast;
   assign req_tready = res_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff   <= '0;
         err_ff     <= ERR_NONE;
         idx_ff     <= '0;
         err_pos_ff <= '0;
      end else begin
         depth_ff   <= depth_in;
         err_ff     <= err_in;
         idx_ff     <= idx_in;
         err_pos_ff <= err_pos_in;
      end
   end

   // same-entry write and read in one cycle: take the written value
   always_ff @(posedge clock) begin
      tos_ff      <= tos_in;
      fwd_ff      <= wr_en && (wr_addr == rd_addr);
      fwd_data_ff <= tos_ff;
   end

   bbc_stack_mem #(
      .STACK_DEPTH (STACK_DEPTH),
      .AW          (AW)
   ) u_stack_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (tos_ff),
      .rd_addr (rd_addr),
      .rd_data (mem_rd_data)
   );

   bbc_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_ready  (res_ready),
      .in_data   (res),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tdata = RSP_TW'(out_data);

   `include "bracket_balance_checker_top_assert.svh"

   `BBC_ASSERT_NOW(a_depth_bound, 1'b1, depth_ff <= DEPTH_FULL, "stack depth beyond capacity")
   `BBC_ASSERT_NEXT(a_last_clears, accept && req_tlast, (depth_ff == '0) && (err_ff == ERR_NONE) && (idx_ff == '0), "state not cleared after last beat")
   `BBC_ASSERT_NEXT(a_err_sticky, (err_ff != ERR_NONE) && !(accept && req_tlast), (err_ff == $past(err_ff)) && (err_pos_ff == $past(err_pos_ff)), "first error overwritten")
   `BBC_ASSERT_NOW(a_empty_ready, !rsp_tvalid, req_tready, "input stalled with empty result buffer")

endmodule

### sv/bbc_stack_mem.sv
// ----------------------------------------------------------------------------
// bbc_stack_mem
// bracket stack storage: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbc_stack_mem #(
   parameter int STACK_DEPTH = 128,
   parameter int AW          = 7
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  bbc_pkg::bracket_type wr_data,
   input  logic [AW-1:0]        rd_addr,
   output bbc_pkg::bracket_type rd_data
);
   import bbc_pkg::*;

   bracket_type stack_ff [STACK_DEPTH];
   bracket_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= stack_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/bbc_out_buf.sv
// ----------------------------------------------------------------------------
// bbc_out_buf
// two-entry result buffer: output register plus skid register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbc_out_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  bbc_pkg::rsp_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output bbc_pkg::rsp_type out_data
);
   import bbc_pkg::*;

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    push;
   logic    main_free;

   assign in_ready  = !skid_valid_ff;
   assign push      = in_valid && in_ready;
   assign main_free = !main_valid_ff || out_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else if (push) begin
            main_in       = in_data;
            main_valid_in = 1'b1;
         end else begin
            main_valid_in = 1'b0;
         end
      end else if (push) begin
         skid_in       = in_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

endmodule
